@@ sv/ppt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared widths, register indexes, prescaler codes and divider bundles for
// the prescaled period timer.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int CNT_W        = 32;   // counter and period width in paired mode
	localparam int CC_W         = 16;   // clock count field
	localparam int PSREM_W      = 8;    // prescaler remainder
	localparam int TICK_W       = CC_W + 1;
	localparam int CYC_W        = CNT_W + 1;
	localparam int MATCH_W      = 16;
	localparam int DIV_CNT_W    = $clog2(TICK_W + 1);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CNT_W-1:0] PERIOD_RST = 32'h0000_FFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PSEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTCLK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd5;

	// prescaler select codes
	localparam logic [1:0] PS_DIV1   = 2'd0;
	localparam logic [1:0] PS_DIV8   = 2'd1;
	localparam logic [1:0] PS_DIV64  = 2'd2;
	localparam logic [1:0] PS_DIV256 = 2'd3;

	// input function codes
	localparam logic FUNC_ADVANCE = 1'b0;
	localparam logic FUNC_GATE    = 1'b1;

	typedef struct packed {
		logic              start;
		logic [TICK_W-1:0] dividend;
		logic [CYC_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TICK_W-1:0] quotient;
		logic [TICK_W-1:0] remainder;
	} div_res_t;

endpackage

@@ sv/ppt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt channel interfaces
// Valid/ready channels for configuration writes, input items and results.
// ----------------------------------------------------------------------------
interface ppt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ppt_pkg::CFG_IDX_W-1:0]    index;
	logic [ppt_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface ppt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [ppt_pkg::CC_W-1:0]    elapsed_clocks;
	logic                        gate_level;

	modport source (output valid, output func, output elapsed_clocks, output gate_level,
		input ready);
	modport sink   (input valid, input func, input elapsed_clocks, input gate_level,
		output ready);
endinterface

interface ppt_out_if;
	logic                          valid;
	logic                          ready;
	logic [ppt_pkg::CNT_W-1:0]     timer_value;
	logic [ppt_pkg::MATCH_W-1:0]   match_total;
	logic                          match_event;
	logic                          interrupt_request;

	modport source (output valid, output timer_value, output match_total,
		output match_event, output interrupt_request, input ready);
	modport sink   (input valid, input timer_value, input match_total,
		input match_event, input interrupt_request, output ready);
endinterface

@@ sv/ppt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_div
// Radix-2 restoring divider, one quotient bit per cycle. Divides the tick
// excess by the period cycle length.
// ----------------------------------------------------------------------------
module ppt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ppt_pkg::div_req_t req,
	output ppt_pkg::div_res_t res
);

	localparam int TW = ppt_pkg::TICK_W;
	localparam int CW = ppt_pkg::CYC_W;
	localparam int NW = ppt_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] quo_q;
	logic [CW-1:0] dvs_q;

	logic [TW:0]   trial;
	logic          fits;
	logic [CW-1:0] diff;

	assign trial = {rem_q, quo_q[TW-1]};
	assign fits  = {{(CW-TW-1){1'b0}}, trial} >= dvs_q;
	assign diff  = {{(CW-TW-1){1'b0}}, trial} - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == NW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(TW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// partial remainder never exceeds the dividend prefix, so it stays TW bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TW-1:0] : trial[TW-1:0];
			quo_q <= {quo_q[TW-2:0], fits};
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule

@@ sv/prescaled_period_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_period_timer
// Period timer with prescaler, 16-bit or paired 32-bit, advanced in closed
// form by elapsed clock counts.
// ----------------------------------------------------------------------------
// Usage:
// cfg is always ready for register writes (index, data); the user must keep
// writes to times the block is idle, as the block leaves this unenforced.
// item carries one transaction per request: func 0 advances the timer by
// elapsed_clocks input clocks, func 1 reports a new gate level. Every item
// produces exactly one result transaction on result. A gate update runs
// through the setup and output states; an advance with zero ticks also the
// plan state, one needing no division also the decide state, and when ticks
// pass the reset point the 17-step divider (one quotient bit per cycle) runs
// in the divide state before the finish state. item.ready is high only while
// the sequencer is idle, so one item is handled at a time.
// A finished result sits in an output register; the next item is accepted
// while it waits. If result stays stalled, the following result is held in
// the sequencer and item.ready stays low until the output register frees.
// Reset clears the counter, prescaler remainder and gate history, sets the
// period to 65535 and zeroes the other settings and the output valid flag.
// ----------------------------------------------------------------------------
module prescaled_period_timer #(
	parameter int COUNT_BITS = ppt_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ppt_cfg_if.sink     cfg,
	ppt_in_if.sink      item,
	ppt_out_if.source   result
);

	localparam int CW = ppt_pkg::CNT_W;
	localparam int TW = ppt_pkg::TICK_W;
	localparam int YW = ppt_pkg::CYC_W;
	localparam int MW = ppt_pkg::MATCH_W;
	localparam int PW = ppt_pkg::PSREM_W;
	localparam logic [CW-1:0] CNT_MASK = CW'((33'd1 << COUNT_BITS) - 33'd1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SETUP  = 7'b0000010,
		S_PLAN   = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_FIN    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [CW-1:0] period_q;
	logic [1:0]    psel_q;
	logic          pair_q;
	logic          gmode_q;
	logic          extclk_q;
	logic          enable_q;

	// timer state
	logic [CW-1:0] count_q;
	logic [PW-1:0] psrem_q;
	logic          gate_prev_q;

	// captured item and working values
	logic                      func_q;
	logic [ppt_pkg::CC_W-1:0]  cc_q;
	logic                      level_q;
	logic [TW-1:0]             ticks_q;
	logic [YW-1:0]             to_reset_q;
	logic                      cur_eq_q;

	// pending result and output register
	logic [CW-1:0] res_count_q;
	logic [MW-1:0] res_matches_q;
	logic          res_irq_q;
	logic          out_valid_q;
	logic [CW-1:0] out_count_q;
	logic [MW-1:0] out_matches_q;
	logic          out_irq_q;

	ppt_pkg::div_req_t div_req;
	ppt_pkg::div_res_t div_res;

	logic [CW-1:0] mask;
	logic [CW-1:0] per_m;
	logic [CW-1:0] cur_m;
	logic          gated;
	logic [TW-1:0] acc;
	logic [TW-1:0] acc_ticks;
	logic [PW-1:0] acc_rem;
	logic [YW:0]   diff;
	logic [YW:0]   to_reset;
	logic [YW-1:0] ticks_ext;
	logic          short_path;
	logic          single_match;
	logic [TW+1:0] match_sum;
	logic [MW-1:0] match_sat;
	logic          load_out;

	assign mask  = pair_q ? {CW{1'b1}} : CNT_MASK;
	assign per_m = period_q & mask;
	assign cur_m = count_q & mask;
	assign gated = gmode_q & ~extclk_q;

	// prescaler: divide by a power of two
	assign acc = TW'(psrem_q) + TW'(cc_q);
	always_comb begin
		case (psel_q)
			ppt_pkg::PS_DIV8: begin
				acc_ticks = acc >> 3;
				acc_rem   = PW'(acc[2:0]);
			end
			ppt_pkg::PS_DIV64: begin
				acc_ticks = acc >> 6;
				acc_rem   = PW'(acc[5:0]);
			end
			ppt_pkg::PS_DIV256: begin
				acc_ticks = acc >> 8;
				acc_rem   = acc[7:0];
			end
			default: begin
				acc_ticks = acc;
				acc_rem   = '0;
			end
		endcase
	end

	// ticks needed to get back to zero from the current count
	assign diff = {2'b00, per_m} - {2'b00, cur_m};
	always_comb begin
		if (cur_m == per_m) begin
			to_reset = (YW+1)'(1);
		end else if (cur_m < per_m) begin
			to_reset = diff + (YW+1)'(1);
		end else begin
			to_reset = {2'b00, mask} + diff + (YW+1)'(2);
		end
	end

	assign ticks_ext    = YW'(ticks_q);
	assign short_path   = ticks_ext < to_reset_q;
	assign single_match = !cur_eq_q && ((ticks_ext + YW'(1)) == to_reset_q);

	// past the reset point: one match per full cycle, one more when the remainder ends on the period, plus the first one
	assign match_sum = (TW+2)'(div_res.quotient)
		+ (TW+2)'(CW'(div_res.remainder) == per_m)
		+ (TW+2)'(!cur_eq_q);
	assign match_sat = (match_sum > (TW+2)'({MW{1'b1}})) ? {MW{1'b1}} : MW'(match_sum);

	always_comb begin
		div_req.start    = (state_q == S_DECIDE) && (ticks_q != '0) && !short_path;
		div_req.dividend = TW'(ticks_ext - to_reset_q);
		div_req.divisor  = YW'(per_m) + YW'(1);
	end

	ppt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign load_out = (state_q == S_OUT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= ppt_pkg::PERIOD_RST;
			psel_q      <= ppt_pkg::PS_DIV1;
			pair_q      <= 1'b0;
			gmode_q     <= 1'b0;
			extclk_q    <= 1'b0;
			enable_q    <= 1'b0;
			count_q     <= '0;
			psrem_q     <= '0;
			gate_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					ppt_pkg::REG_PERIOD: period_q <= cfg.data;
					ppt_pkg::REG_PSEL:   psel_q   <= cfg.data[1:0];
					ppt_pkg::REG_PAIR:   pair_q   <= cfg.data[0];
					ppt_pkg::REG_GATE:   gmode_q  <= cfg.data[0];
					ppt_pkg::REG_EXTCLK: extclk_q <= cfg.data[0];
					ppt_pkg::REG_ENABLE: enable_q <= cfg.data[0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					count_q <= cur_m;
					if (func_q == ppt_pkg::FUNC_GATE) begin
						gate_prev_q <= level_q;
						state_q     <= S_OUT;
					end else begin
						psrem_q <= acc_rem;
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					state_q <= (ticks_q == '0) ? S_OUT : S_DECIDE;
				end
				S_DECIDE: begin
					if (short_path) begin
						count_q <= (cur_m + CW'(ticks_q)) & mask;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					count_q <= CW'(div_res.remainder);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			func_q  <= item.func;
			cc_q    <= item.elapsed_clocks;
			level_q <= item.gate_level;
		end

		case (state_q)
			S_SETUP: begin
				ticks_q       <= acc_ticks;
				res_count_q   <= cur_m;
				res_matches_q <= '0;
				res_irq_q     <= (func_q == ppt_pkg::FUNC_GATE) && gate_prev_q && !level_q
					&& enable_q && gated && (per_m != '0);
			end
			S_PLAN: begin
				to_reset_q <= to_reset[YW-1:0];
				cur_eq_q   <= cur_m == per_m;
			end
			S_DECIDE: begin
				if (short_path) begin
					res_count_q   <= (cur_m + CW'(ticks_q)) & mask;
					res_matches_q <= MW'(single_match && (per_m != '0));
					res_irq_q     <= single_match && (per_m != '0) && !gated;
				end
			end
			S_FIN: begin
				res_count_q   <= CW'(div_res.remainder);
				res_matches_q <= (per_m != '0) ? match_sat : '0;
				res_irq_q     <= (per_m != '0) && (match_sat != '0) && !gated;
			end
			default: ;
		endcase

		if (load_out) begin
			out_count_q   <= res_count_q;
			out_matches_q <= res_matches_q;
			out_irq_q     <= res_irq_q;
		end
	end

	assign cfg.ready  = 1'b1;
	assign item.ready = state_q == S_IDLE;

	assign result.valid             = out_valid_q;
	assign result.timer_value       = out_count_q;
	assign result.match_total       = out_matches_q;
	assign result.match_event       = out_matches_q != '0;
	assign result.interrupt_request = out_irq_q;

endmodule
